### hw/rtl/wide_char_integer_parser_macros.svh
// assertion macros for the wide character integer parser
`ifndef WIDE_CHAR_INTEGER_PARSER_MACROS_SVH
`define WIDE_CHAR_INTEGER_PARSER_MACROS_SVH

`ifndef SYNTH
`define WCIP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define WCIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WCIP_ASSERT(lbl, ante, cons, msg)
`define WCIP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### hw/rtl/wcip_pkg.sv
package wcip_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 16;

  localparam int unsigned CH_W      = 32;
  localparam int unsigned NUM_W     = 64;
  localparam int unsigned BASE_W    = 6;
  localparam int unsigned DIG_W     = 6;
  localparam int unsigned ACC_W     = NUM_W + 7;
  localparam int unsigned END_W     = 16;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 2'd1;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_BASE = 2'd2;

  localparam logic [NUM_W-1:0] LIM_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [NUM_W-1:0] LIM_NEG = 64'h8000_0000_0000_0000;
  localparam logic [NUM_W-1:0] LIM_UNS = 64'hffff_ffff_ffff_ffff;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
  localparam logic [BASE_W-1:0] BASE_BIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

  localparam logic [CH_W-1:0] CASE_BIT = 32'h20;
  localparam logic [CH_W-1:0] CH_SPACE = 32'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 32'h09;
  localparam logic [CH_W-1:0] CH_CR    = 32'h0d;
  localparam logic [CH_W-1:0] CH_0     = 32'h30;
  localparam logic [CH_W-1:0] CH_9     = 32'h39;
  localparam logic [CH_W-1:0] CH_A_LO  = 32'h61;
  localparam logic [CH_W-1:0] CH_Z_LO  = 32'h7a;
  localparam logic [CH_W-1:0] CH_B_LO  = 32'h62;
  localparam logic [CH_W-1:0] CH_X_LO  = 32'h78;
  localparam logic [CH_W-1:0] CH_MINUS = 32'h2d;
  localparam logic [CH_W-1:0] CH_PLUS  = 32'h2b;
  localparam logic [DIG_W-1:0] ALPHA_OFS = 6'd10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_X,
    PH_B,
    PH_DIGITS
  } phase_e;

  typedef enum logic [1:0] {
    CTL_READY,
    CTL_MAC,
    CTL_EMIT
  } ctl_e;

  typedef struct packed {
    logic             is_blank;
    logic             is_minus;
    logic             is_plus;
    logic             is_zero;
    logic             is_x;
    logic             is_b;
    logic             is_dec;
    logic             dig_ok;
    logic [DIG_W-1:0] dig;
  } cls_t;

  typedef struct packed {
    logic              start;
    logic [BASE_W-1:0] base;
    logic [DIG_W-1:0]  digit;
  } mac_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } mac_rsp_t;

endpackage

### hw/rtl/wcip_classify.sv
module wcip_classify (
  input  logic [wcip_pkg::CH_W-1:0] ch_i,
  output wcip_pkg::cls_t            cls_o
);
  import wcip_pkg::*;

  logic [CH_W-1:0] lower;
  logic [CH_W-1:0] sub_dec;
  logic [CH_W-1:0] sub_alpha;
  logic            is_alpha;

  assign lower     = ch_i | CASE_BIT;
  assign sub_dec   = ch_i - CH_0;
  assign sub_alpha = lower - CH_A_LO;
  assign is_alpha  = (lower >= CH_A_LO) && (lower <= CH_Z_LO);

  always_comb begin
    cls_o.is_blank = (ch_i == CH_SPACE) || ((ch_i >= CH_TAB) && (ch_i <= CH_CR));
    cls_o.is_minus = (ch_i == CH_MINUS);
    cls_o.is_plus  = (ch_i == CH_PLUS);
    cls_o.is_zero  = (ch_i == CH_0);
    cls_o.is_x     = (lower == CH_X_LO);
    cls_o.is_b     = (lower == CH_B_LO);
    cls_o.is_dec   = (ch_i >= CH_0) && (ch_i <= CH_9);
    cls_o.dig_ok   = cls_o.is_dec || is_alpha;
    if (cls_o.is_dec) begin
      cls_o.dig = sub_dec[DIG_W-1:0];
    end else if (is_alpha) begin
      cls_o.dig = sub_alpha[DIG_W-1:0] + ALPHA_OFS;
    end else begin
      cls_o.dig = '0;
    end
  end

endmodule

### hw/rtl/wcip_mac.sv
module wcip_mac (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wcip_pkg::mac_req_t         req_i,
  input  logic [wcip_pkg::NUM_W-1:0] mag_i,
  input  logic [wcip_pkg::NUM_W-1:0] lim_i,
  output wcip_pkg::mac_rsp_t         rsp_o,
  output logic [wcip_pkg::NUM_W-1:0] mag_o
);
  import wcip_pkg::*;

  logic              busy_q;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  m_q;
  logic [BASE_W-1:0] b_q;
  logic [NUM_W-1:0]  lim_q;

  // shift-add: one base bit per cycle, lsb first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (busy_q && (b_q == '0)) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= ACC_W'(req_i.digit);
      m_q   <= ACC_W'(mag_i);
      b_q   <= req_i.base;
      lim_q <= lim_i;
    end else if (busy_q && (b_q != '0)) begin
      if (b_q[0]) begin
        acc_q <= acc_q + m_q;
      end
      m_q <= m_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign rsp_o.done = busy_q && (b_q == '0);
  assign rsp_o.ovf  = acc_q > ACC_W'(lim_q);
  assign mag_o      = acc_q[NUM_W-1:0];

endmodule

### hw/rtl/wide_char_integer_parser.sv
// Streaming wide-character string-to-integer converter (strtol style, 64 bit). Characters
// of a string arrive one per transaction, first_i marking the start of a new string; one
// result transaction follows the first character that cannot be consumed (NUL always ends
// the string), or the first character at once when the base register is invalid. Base is
// latched at the first character; is_signed is used live. Write configuration only while
// idle. A digit goes through a shared shift-add unit that handles one base bit per cycle
// plus a final overflow compare, with the input stalled meanwhile; whitespace, sign and
// prefix characters bypass it. The terminating character passes through an emit step,
// which waits while a previous result is still held on the output.
`include "wide_char_integer_parser_macros.svh"

module wide_char_integer_parser #(
  parameter int unsigned OFFSET_BITS = wcip_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wcip_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wcip_pkg::BASE_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [wcip_pkg::CH_W-1:0]      ch_i,
  input  logic                           first_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [wcip_pkg::NUM_W-1:0]     number_o,
  output logic [wcip_pkg::END_W-1:0]     end_offset_o,
  output logic [wcip_pkg::STAT_W-1:0]    status_o,
  output logic                           converted_o
);
  import wcip_pkg::*;

  localparam logic [OFFSET_BITS-1:0] IDX_MAX = {OFFSET_BITS{1'b1}};

  logic [BASE_W-1:0]      base_q;
  logic                   signed_q;
  ctl_e                   ctl_q, ctl_d;
  phase_e                 phase_q, phase_d;
  logic [NUM_W-1:0]       mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic                   ovf_q, ovf_d;
  logic                   dseen_q, dseen_d;
  logic [OFFSET_BITS-1:0] idx_q, idx_d;
  logic [BASE_W-1:0]      wb_q, wb_d;
  logic [OFFSET_BITS-1:0] end_q, end_d;
  logic                   bad_q, bad_d;

  logic                   out_valid_q;
  logic [NUM_W-1:0]       number_q;
  logic [END_W-1:0]       end_offset_q;
  logic [STAT_W-1:0]      status_q;
  logic                   converted_q;

  cls_t                   cls;
  mac_req_t               mac_req;
  mac_rsp_t               mac_rsp;
  logic [NUM_W-1:0]       mac_mag;
  logic [NUM_W-1:0]       limit;

  logic                   accept;
  logic                   run;
  phase_e                 ph_cur;
  logic                   want_sig;
  logic                   do_feed;
  logic [BASE_W-1:0]      feed_base;
  logic                   go_emit;
  logic [OFFSET_BITS-1:0] idx_inc;
  logic [OFFSET_BITS-1:0] idx_prev;
  logic                   out_free;
  logic                   load;
  logic [NUM_W-1:0]       num_res;
  logic [OFFSET_BITS+END_W-1:0] end_ext;

  wcip_classify u_classify (
    .ch_i  (ch_i),
    .cls_o (cls)
  );

  wcip_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .mag_i  (mag_d),
    .lim_i  (limit),
    .rsp_o  (mac_rsp),
    .mag_o  (mac_mag)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BASE_RESET;
      signed_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BASE:   base_q   <= cfg_data_i;
        CFG_SIGNED: signed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign idx_inc  = (idx_q == IDX_MAX) ? idx_q : idx_q + OFFSET_BITS'(1);
  assign idx_prev = ((idx_inc == IDX_MAX) || (idx_inc == '0)) ? idx_inc
                                                              : idx_inc - OFFSET_BITS'(1);
  assign limit    = !signed_q ? LIM_UNS : (neg_d ? LIM_NEG : LIM_POS);

  // parse state update
  always_comb begin
    phase_d   = phase_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    ovf_d     = ovf_q;
    dseen_d   = dseen_q;
    idx_d     = idx_q;
    wb_d      = wb_q;
    end_d     = end_q;
    bad_d     = bad_q;
    run       = 1'b0;
    ph_cur    = phase_q;
    want_sig  = 1'b0;
    do_feed   = 1'b0;
    feed_base = wb_q;
    go_emit   = 1'b0;
    mac_req   = '{start: 1'b0, base: wb_q, digit: cls.dig};

    if (ctl_q == CTL_MAC && mac_rsp.done) begin
      if (mac_rsp.ovf) begin
        ovf_d = 1'b1;
      end else begin
        mag_d = mac_mag;
      end
    end

    if (accept) begin
      if (first_i) begin
        mag_d   = '0;
        neg_d   = 1'b0;
        ovf_d   = 1'b0;
        dseen_d = 1'b0;
        idx_d   = '0;
        wb_d    = base_q;
        if ((base_q == BASE_ONE) || (base_q > BASE_MAX)) begin
          go_emit = 1'b1;
          bad_d   = 1'b1;
          end_d   = '0;
          phase_d = PH_IDLE;
        end else begin
          run    = 1'b1;
          ph_cur = PH_SPACE;
        end
      end else if (phase_q != PH_IDLE) begin
        idx_d = idx_inc;
        run   = 1'b1;
      end
    end

    if (run) begin
      case (ph_cur)
        PH_SPACE: begin
          if (cls.is_blank) begin
            phase_d = PH_SPACE;
          end else if (cls.is_minus || cls.is_plus) begin
            neg_d   = cls.is_minus;
            phase_d = PH_SIGNED;
          end else begin
            want_sig = 1'b1;
          end
        end
        PH_SIGNED: begin
          want_sig = 1'b1;
        end
        PH_ZERO: begin
          if (cls.is_x && ((wb_d == BASE_AUTO) || (wb_d == BASE_HEX))) begin
            phase_d = PH_X;
          end else if (cls.is_b && ((wb_d == BASE_AUTO) || (wb_d == BASE_BIN))) begin
            phase_d = PH_B;
          end else begin
            dseen_d   = 1'b1;
            do_feed   = 1'b1;
            feed_base = (wb_d == BASE_AUTO) ? BASE_OCT : wb_d;
          end
        end
        PH_X: begin
          if (cls.dig_ok && (cls.dig < BASE_HEX)) begin
            do_feed   = 1'b1;
            feed_base = BASE_HEX;
          end else begin
            dseen_d = 1'b1;
            go_emit = 1'b1;
            bad_d   = 1'b0;
            end_d   = idx_prev;
            phase_d = PH_IDLE;
          end
        end
        PH_B: begin
          if (cls.is_dec) begin
            do_feed   = 1'b1;
            feed_base = BASE_BIN;
          end else begin
            dseen_d = 1'b1;
            go_emit = 1'b1;
            bad_d   = 1'b0;
            end_d   = idx_prev;
            phase_d = PH_IDLE;
          end
        end
        PH_DIGITS: begin
          do_feed   = 1'b1;
          feed_base = wb_d;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    if (want_sig) begin
      if (cls.is_zero && ((wb_d == BASE_AUTO) || (wb_d == BASE_HEX) ||
                          (wb_d == BASE_BIN))) begin
        phase_d = PH_ZERO;
      end else begin
        do_feed   = 1'b1;
        feed_base = (wb_d == BASE_AUTO) ? BASE_DEC : wb_d;
      end
    end

    if (do_feed) begin
      wb_d    = feed_base;
      phase_d = PH_DIGITS;
      if (cls.dig_ok && (cls.dig < feed_base)) begin
        dseen_d       = 1'b1;
        mac_req.start = !ovf_d;
        mac_req.base  = feed_base;
      end else begin
        go_emit = 1'b1;
        bad_d   = 1'b0;
        end_d   = idx_d;
        phase_d = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= CTL_READY;
      phase_q <= PH_IDLE;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      dseen_q <= 1'b0;
      idx_q   <= '0;
      wb_q    <= '0;
      bad_q   <= 1'b0;
    end else begin
      ctl_q   <= ctl_d;
      phase_q <= phase_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      dseen_q <= dseen_d;
      idx_q   <= idx_d;
      wb_q    <= wb_d;
      bad_q   <= bad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    end_q <= end_d;
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer next state
  always_comb begin
    ctl_d = ctl_q;
    case (ctl_q)
      CTL_READY: begin
        if (mac_req.start) begin
          ctl_d = CTL_MAC;
        end else if (go_emit) begin
          ctl_d = CTL_EMIT;
        end
      end
      CTL_MAC: begin
        if (mac_rsp.done) begin
          ctl_d = CTL_READY;
        end
      end
      CTL_EMIT: begin
        if (out_free) begin
          ctl_d = CTL_READY;
        end
      end
      default: ctl_d = CTL_READY;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    load       = 1'b0;
    case (ctl_q)
      CTL_READY: in_stall_o = 1'b0;
      CTL_MAC:   in_stall_o = 1'b1;
      CTL_EMIT:  load       = out_free;
      default:   in_stall_o = 1'b1;
    endcase
  end

  assign end_ext = (OFFSET_BITS + END_W)'(end_q);

  always_comb begin
    if (bad_q) begin
      num_res = '0;
    end else if (ovf_q) begin
      num_res = !signed_q ? LIM_UNS : (neg_q ? LIM_NEG : LIM_POS);
    end else begin
      num_res = neg_q ? (NUM_W'(0) - mag_q) : mag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      number_q     <= num_res;
      end_offset_q <= (!bad_q && dseen_q) ? end_ext[END_W-1:0] : '0;
      status_q     <= bad_q ? STAT_BAD_BASE : (ovf_q ? STAT_RANGE : STAT_OK);
      converted_q  <= !bad_q && dseen_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign number_o     = number_q;
  assign end_offset_o = end_offset_q;
  assign status_o     = status_q;
  assign converted_o  = converted_q;

  `WCIP_ASSERT_NEXT(a_mac_returns, (ctl_q == CTL_MAC) && mac_rsp.done, ctl_q == CTL_READY, "sequencer missed mac completion")
  `WCIP_ASSERT(a_mac_idle, mac_rsp.done, ctl_q == CTL_MAC, "mac completion outside mac state")
  `WCIP_ASSERT(a_load_from_emit, $rose(out_valid_o), $past(ctl_q == CTL_EMIT), "result without emit step")
  `WCIP_ASSERT(a_no_conv_no_end, out_valid_o && !converted_o, end_offset_o == '0, "end offset without conversion")
  `WCIP_ASSERT(a_bad_base_zero, out_valid_o && (status_o == STAT_BAD_BASE), (number_o == '0) && !converted_o, "invalid base result not cleared")

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wcip_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned OFFSET_MAX = (1 << OFFSET_BITS_DEF) - 1;
  localparam int unsigned N_PHASES = 18;
  localparam int unsigned PHASE_ITEMS = 64;
  localparam int unsigned SETTLE = 30;
  localparam logic [CH_W-1:0] CH_NUL = 32'h0;

  typedef struct packed {
    logic [NUM_W-1:0]  number;
    logic [END_W-1:0]  end_offset;
    logic [STAT_W-1:0] status;
    logic              converted;
  } parse_result_t;

  class parse_scoreboard;
    logic [BASE_W-1:0] base_reg;
    bit                signed_reg;
    phase_e            phase;
    logic [NUM_W-1:0]  mag;
    bit                neg;
    bit                ovf;
    bit                dig_seen;
    int unsigned       idx;
    logic [BASE_W-1:0] wbase;
    parse_result_t     expected_q[$];
    int unsigned       errors;

    function new();
      base_reg = BASE_RESET;
      signed_reg = 1'b1;
      phase = PH_IDLE;
      mag = '0;
      neg = 1'b0;
      ovf = 1'b0;
      dig_seen = 1'b0;
      idx = 0;
      wbase = BASE_AUTO;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [BASE_W-1:0] value);
      if (index == CFG_BASE) begin
        base_reg = value;
      end else if (index == CFG_SIGNED) begin
        signed_reg = value[0];
      end
    endfunction

    function bit is_blank(logic [CH_W-1:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function int unsigned digit_val(logic [CH_W-1:0] c);
      logic [CH_W-1:0] l;
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      l = c | CASE_BIT;
      if (l >= CH_A_LO && l <= CH_Z_LO) return int'(ALPHA_OFS) + int'(l - CH_A_LO);
      return 99;
    endfunction

    function void add_digit(int unsigned d);
      logic [NUM_W-1:0] lim;
      logic [NUM_W-1:0] b;
      if (!signed_reg) lim = LIM_UNS;
      else lim = neg ? LIM_NEG : LIM_POS;
      b = (wbase != BASE_AUTO) ? 64'(wbase) : 64'(BASE_DEC);
      dig_seen = 1'b1;
      if (ovf) return;
      if (mag > (lim - 64'(d)) / b) ovf = 1'b1;
      else mag = mag * b + 64'(d);
    endfunction

    function void post_result(int unsigned end_idx, bit bad_base);
      parse_result_t r;
      r.number = '0;
      r.status = STAT_OK;
      if (bad_base) begin
        r.status = STAT_BAD_BASE;
      end else if (ovf) begin
        r.status = STAT_RANGE;
        if (!signed_reg) r.number = LIM_UNS;
        else r.number = neg ? LIM_NEG : LIM_POS;
      end else begin
        r.number = neg ? (64'd0 - mag) : mag;
      end
      r.end_offset = (bad_base || !dig_seen) ? '0 : end_idx[END_W-1:0];
      r.converted = !bad_base && dig_seen;
      expected_q.push_back(r);
      phase = PH_IDLE;
    endfunction

    function void take_char(logic [CH_W-1:0] c);
      if (digit_val(c) < int'(wbase)) add_digit(digit_val(c));
      else post_result(idx, 1'b0);
    endfunction

    function int unsigned prev_index();
      if (idx >= OFFSET_MAX || idx == 0) return idx;
      return idx - 1;
    endfunction

    function void take_first(logic [CH_W-1:0] c);
      if (c == CH_0 && (wbase == BASE_AUTO || wbase == BASE_HEX || wbase == BASE_BIN)) begin
        phase = PH_ZERO;
        return;
      end
      if (wbase == BASE_AUTO) wbase = BASE_DEC;
      phase = PH_DIGITS;
      take_char(c);
    endfunction

    // prefix that is not followed by a digit: value 0 ending at the x or b
    function void end_at_prefix();
      if (wbase == BASE_AUTO) wbase = BASE_OCT;
      add_digit(0);
      post_result(prev_index(), 1'b0);
    endfunction

    function void note_char(logic [CH_W-1:0] c, logic is_first);
      if (is_first) begin
        mag = '0;
        neg = 1'b0;
        ovf = 1'b0;
        dig_seen = 1'b0;
        idx = 0;
        wbase = base_reg;
        if (base_reg == BASE_ONE || base_reg > BASE_MAX) begin
          post_result(0, 1'b1);
          return;
        end
        phase = PH_SPACE;
      end else begin
        if (phase == PH_IDLE) return;
        if (idx < OFFSET_MAX) idx++;
      end
      case (phase)
        PH_SPACE: begin
          if (is_blank(c)) return;
          if (c == CH_MINUS || c == CH_PLUS) begin
            neg = (c == CH_MINUS);
            phase = PH_SIGNED;
            return;
          end
          take_first(c);
        end
        PH_SIGNED: take_first(c);
        PH_ZERO: begin
          if ((c | CASE_BIT) == CH_X_LO && (wbase == BASE_AUTO || wbase == BASE_HEX)) begin
            phase = PH_X;
            return;
          end
          if ((c | CASE_BIT) == CH_B_LO && (wbase == BASE_AUTO || wbase == BASE_BIN)) begin
            phase = PH_B;
            return;
          end
          if (wbase == BASE_AUTO) wbase = BASE_OCT;
          add_digit(0);
          phase = PH_DIGITS;
          take_char(c);
        end
        PH_X: begin
          if (digit_val(c) < int'(BASE_HEX)) begin
            wbase = BASE_HEX;
            phase = PH_DIGITS;
            take_char(c);
          end else begin
            end_at_prefix();
          end
        end
        PH_B: begin
          if (c >= CH_0 && c <= CH_9) begin
            wbase = BASE_BIN;
            phase = PH_DIGITS;
            take_char(c);
          end else begin
            end_at_prefix();
          end
        end
        PH_DIGITS: take_char(c);
        default: phase = PH_IDLE;
      endcase
    endfunction

    function void check_result(parse_result_t r);
      parse_result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: number %h end %0d status %0d conv %0d",
                   r.number, r.end_offset, r.status, r.converted);
        end
        return;
      end
      e = expected_q.pop_front();
      if (e.number !== r.number || e.end_offset !== r.end_offset ||
          e.status !== r.status || e.converted !== r.converted) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch: expected number %h end %0d status %0d conv %0d",
                   e.number, e.end_offset, e.status, e.converted);
          $display("                 actual   number %h end %0d status %0d conv %0d",
                   r.number, r.end_offset, r.status, r.converted);
        end
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [BASE_W-1:0]    cfg_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CH_W-1:0]      ch_i;
  logic                 first_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [NUM_W-1:0]     number_o;
  logic [END_W-1:0]     end_offset_o;
  logic [STAT_W-1:0]    status_o;
  logic                 converted_o;

  parse_scoreboard sb;
  logic [CH_W-1:0] str_q[$];
  int unsigned     sent;
  int unsigned     cycles;
  bit              idle_on;
  bit              hold_req;
  int unsigned     hold_left;
  int unsigned     stall_left;
  int unsigned     run_left;

  wide_char_integer_parser uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .ch_i         (ch_i),
    .first_i      (first_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .number_o     (number_o),
    .end_offset_o (end_offset_o),
    .status_o     (status_o),
    .converted_o  (converted_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stall bursts plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
      out_stall_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_stall_i <= 1'b1;
    end else begin
      run_left = $urandom_range(0, 15);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    parse_result_t r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      r.number = number_o;
      r.end_offset = end_offset_o;
      r.status = status_o;
      r.converted = converted_o;
      sb.check_result(r);
    end
  end

  // write enable stays high; the caller drops it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [BASE_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.write_reg(index, value);
  endtask

  task automatic send_item(logic [CH_W-1:0] c, logic is_first);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= c;
    first_i <= is_first;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_char(c, is_first);
    sent++;
  endtask

  task automatic send_text(string s, bit with_nul);
    for (int i = 0; i < s.len(); i++) begin
      send_item({24'd0, s[i]}, i == 0);
    end
    if (with_nul) send_item(CH_NUL, 1'b0);
  endtask

  // wait for every outstanding result, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [CH_W-1:0] digit_char(int unsigned d);
    logic [CH_W-1:0] c;
    if (d < int'(ALPHA_OFS)) return CH_0 + d;
    c = CH_A_LO + d - int'(ALPHA_OFS);
    if ($urandom_range(0, 1)) c = c & ~CASE_BIT;
    return c;
  endfunction

  task automatic push_number(logic [NUM_W-1:0] v, int unsigned radix);
    int unsigned dq[$];
    if (v == 0) dq.push_front(0);
    while (v != 0) begin
      dq.push_front(32'(v % 64'(radix)));
      v = v / 64'(radix);
    end
    foreach (dq[i]) str_q.push_back(digit_char(dq[i]));
  endtask

  task automatic gen_string();
    int unsigned b;
    int unsigned radix;
    int unsigned mode;
    int unsigned pick;
    logic [NUM_W-1:0] v;
    logic [CH_W-1:0] c;
    str_q.delete();
    b = 32'(sb.base_reg);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) send_item($urandom, 1'($urandom_range(0, 1)));
    end
    repeat ($urandom_range(0, 2)) begin
      str_q.push_back($urandom_range(0, 1) ? CH_SPACE : 32'($urandom_range(9, 13)));
    end
    pick = $urandom_range(0, 3);
    if (pick == 0) str_q.push_back(CH_PLUS);
    else if (pick == 1) str_q.push_back(CH_MINUS);
    mode = 0;
    if (b == BASE_AUTO) mode = $urandom_range(0, 3);
    else if (b == BASE_HEX) mode = $urandom_range(0, 1) * 2;
    else if (b == BASE_BIN) mode = $urandom_range(0, 1) * 3;
    case (mode)
      1: radix = 32'(BASE_OCT);
      2: radix = 32'(BASE_HEX);
      3: radix = 32'(BASE_BIN);
      default: radix = (b >= BASE_BIN && b <= BASE_MAX) ? b : 32'(BASE_DEC);
    endcase
    if (mode != 0) str_q.push_back(CH_0);
    if (mode >= 2) begin
      c = (mode == 2) ? CH_X_LO : CH_B_LO;
      if ($urandom_range(0, 1)) c = c & ~CASE_BIT;
      str_q.push_back(c);
    end
    if (mode >= 2 && $urandom_range(0, 5) == 0) begin
      // prefix with nothing or a random digit character behind it
      if ($urandom_range(0, 1)) str_q.push_back(digit_char($urandom_range(0, 35)));
    end else begin
      pick = $urandom_range(0, 5);
      case (pick)
        0: v = LIM_POS + $urandom_range(0, 2) - 1;
        1: v = LIM_NEG + $urandom_range(0, 2) - 1;
        2: v = LIM_UNS - $urandom_range(0, 2);
        3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        default: v = $urandom_range(0, 5000);
      endcase
      if ($urandom_range(0, 7) == 0) str_q.push_back(CH_0);
      push_number(v, radix);
    end
    pick = $urandom_range(0, 9);
    if (pick <= 4) begin
      str_q.push_back(CH_NUL);
    end else if (pick == 5) begin
      str_q.push_back($urandom);
    end else if (pick <= 7) begin
      str_q.push_back(32'($urandom_range(32'h20, 32'h7e)));
    end else if (pick == 9) begin
      str_q.push_back(CH_NUL);
      repeat ($urandom_range(1, 3)) str_q.push_back($urandom);
    end
    foreach (str_q[i]) send_item(str_q[i], i == 0);
  endtask

  initial begin
    int unsigned base_plan[N_PHASES];
    bit          signed_plan[N_PHASES];
    int unsigned quota;
    base_plan = '{10, 0, 2, 36, 16, 1, 0, 8, 37, 63, 16, 2, 36, 0, 10, 0, 16, 0};
    signed_plan = '{1, 1, 0, 1, 0, 1, 0, 1, 0, 1, 1, 1, 0, 0, 1, 0, 1, 1};
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_BASE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    ch_i = '0;
    first_i = 1'b0;
    out_stall_i = 1'b0;
    sent = 0;
    cycles = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    run_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed transactions with the reset configuration
    send_item(32'hffff_ffff, 1'b0);
    send_text(" \t-7", 1'b1);
    send_text("12", 1'b0);
    send_text("+3z", 1'b0);
    send_text("-0", 1'b1);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p >= N_PHASES - 2) begin
        base_plan[p] = $urandom_range(0, 40);
        signed_plan[p] = 1'($urandom_range(0, 1));
      end
      write_reg(CFG_BASE, BASE_W'(base_plan[p]));
      write_reg(CFG_SIGNED, {5'd0, signed_plan[p]});
      cfg_we_i <= 1'b0;
      idle_on = (p < N_PHASES - 3) && ($urandom_range(0, 4) != 0);
      if (p == 3) hold_req = 1'b1;
      quota = sent + PHASE_ITEMS;
      while (sent < quota) gen_string();
      send_item(CH_NUL, 1'b0);
      drain();
    end

    sb.errors += sb.expected_q.size();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
